// ----- rtl/dlup_pkg.sv -----
// Shared types, character codes and lookup tables for the length token parser.
// Used by the interfaces' users, the scanner, the result formatter and the top level.
// Depends on nothing.
package dlup_pkg;

  // Scanner phases.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WS,
    PH_SIGN,
    PH_INT,
    PH_DOT,
    PH_FRAC1,
    PH_FRAC2,
    PH_UNIT2
  } dlup_phase_t;

  // First letter of a two letter unit.
  typedef enum logic [2:0] {
    UF_E,
    UF_P,
    UF_M,
    UF_C,
    UF_I
  } dlup_uf_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK,
    ST_NONUM,
    ST_RANGE
  } dlup_status_t;

  localparam int MAG_W   = 24;
  localparam int FRAC_W  = 7;
  localparam int VALUE_W = 25;

  localparam logic [MAG_W-1:0] MAG_CAP     = 24'd8388736;
  localparam logic [MAG_W-1:0] INT_POS_MAX = 24'd32767;
  localparam logic [MAG_W-1:0] INT_NEG_MAX = 24'd32768;

  localparam logic signed [VALUE_W:0] VAL_LOW  = -26'sd8388736;
  localparam logic signed [VALUE_W:0] VAL_HIGH = 26'sd8388607;

  // Character codes.
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PCT   = 8'd37;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_LC_A  = 8'd97;
  localparam logic [7:0] CH_LC_Z  = 8'd122;
  localparam logic [7:0] CH_CASE  = 8'd32;
  localparam logic [7:0] CH_E     = 8'd69;
  localparam logic [7:0] CH_M     = 8'd77;
  localparam logic [7:0] CH_X     = 8'd88;
  localparam logic [7:0] CH_P     = 8'd80;
  localparam logic [7:0] CH_C     = 8'd67;
  localparam logic [7:0] CH_T     = 8'd84;
  localparam logic [7:0] CH_I     = 8'd73;
  localparam logic [7:0] CH_N     = 8'd78;

  localparam logic [15:0] UNIT_NONE = 16'h0000;
  localparam logic [15:0] UNIT_PCT  = 16'h2500;

  localparam int Frac1Den = 10;
  localparam int Frac2Den = 100;

  // Rounded 8-bit fraction for one fraction digit: (f*256+5)/10.
  function automatic logic [15:0][7:0] build_frac1_lut();
    logic [15:0][7:0] t;
    for (int i = 0; i < 16; i++) begin
      t[i] = (i < Frac1Den) ? 8'((i * 256 + 5) / Frac1Den) : 8'd0;
    end
    return t;
  endfunction

  // Rounded 8-bit fraction for two fraction digits: (f*256+5)/100.
  function automatic logic [127:0][7:0] build_frac2_lut();
    logic [127:0][7:0] t;
    for (int i = 0; i < 128; i++) begin
      t[i] = (i < Frac2Den) ? 8'((i * 256 + 5) / Frac2Den) : 8'd0;
    end
    return t;
  endfunction

  localparam logic [15:0][7:0]  FRAC1_LUT = build_frac1_lut();
  localparam logic [127:0][7:0] FRAC2_LUT = build_frac2_lut();

  // Everything the formatter needs to build one result.
  typedef struct packed {
    logic              nonum;
    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [FRAC_W-1:0] frac;
    logic [1:0]        frac_digits;
    logic [15:0]       unit;
    logic [7:0]        consumed;
  } dlup_emit_t;

  function automatic logic [7:0] uf_char(dlup_uf_t uf);
    logic [7:0] c;
    case (uf)
      UF_E:    c = CH_E;
      UF_P:    c = CH_P;
      UF_M:    c = CH_M;
      UF_C:    c = CH_C;
      UF_I:    c = CH_I;
      default: c = CH_E;
    endcase
    return c;
  endfunction

  function automatic logic unit_pair_ok(dlup_uf_t uf, logic [7:0] b);
    logic ok;
    case (uf)
      UF_E:    ok = (b == CH_M) || (b == CH_X);
      UF_P:    ok = (b == CH_C) || (b == CH_T) || (b == CH_X);
      UF_M:    ok = (b == CH_M);
      UF_C:    ok = (b == CH_M);
      UF_I:    ok = (b == CH_N);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ----- rtl/dlup_if.sv -----
// Valid/ready channel interfaces for the length token parser.
// One carries text characters in, the other carries parse results out.
// Depends on nothing.
interface dlup_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       first;
  logic       end_of_text;

  modport source (output valid, output ch, output first, output end_of_text, input ready);
  modport sink   (input valid, input ch, input first, input end_of_text, output ready);
endinterface

interface dlup_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [24:0] value;
  logic [15:0]        unit;
  logic [7:0]         consumed;

  modport source (output valid, output status, output value, output unit, output consumed,
                  input ready);
  modport sink   (input valid, input status, input value, input unit, input consumed,
                  output ready);
endinterface

// ----- rtl/dlup_scan.sv -----
// Character scanner: phase register, accumulators and per-character update.
// Depends on dlup_pkg.
module dlup_scan #(
  parameter int MAX_SCAN_LENGTH = 255
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           ch,
  input  logic                 first,
  input  logic                 end_of_text,
  output logic                 emit_valid,
  output dlup_pkg::dlup_emit_t emit
);
  import dlup_pkg::*;

  localparam int CW  = $clog2(MAX_SCAN_LENGTH + 1);
  localparam int CXW = (CW > 8) ? CW : 8;
  localparam logic [CW:0]    CNT_MAX  = (CW + 1)'(MAX_SCAN_LENGTH);
  localparam logic [CXW-1:0] CONS_MAX = CXW'(255);

  dlup_phase_t       phase_r, phase_nxt;
  logic [MAG_W-1:0]  int_r, int_nxt;
  logic              neg_r, neg_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [1:0]        fd_r, fd_nxt;
  dlup_uf_t          uf_r, uf_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [1:0]        cnt_add;

  // A new scan behaves as if the state had just been cleared, with the phase set to white space.
  dlup_phase_t       eff_phase;
  logic [MAG_W-1:0]  eff_int;
  logic              eff_neg;
  logic [FRAC_W-1:0] eff_frac;
  logic [1:0]        eff_fd;
  dlup_uf_t          eff_uf;
  logic [CW-1:0]     eff_cnt;

  assign eff_phase = first ? PH_WS : phase_r;
  assign eff_int   = first ? '0 : int_r;
  assign eff_neg   = first ? 1'b0 : neg_r;
  assign eff_frac  = first ? '0 : frac_r;
  assign eff_fd    = first ? 2'd0 : fd_r;
  assign eff_uf    = first ? UF_E : uf_r;
  assign eff_cnt   = first ? '0 : cnt_r;

  // Character classes.
  logic       is_space, is_digit, is_sign, is_dot, is_pct, is_unit1, pair_ok;
  logic [7:0] up;
  logic [3:0] digit;
  dlup_uf_t   uf_code;

  assign up       = (ch >= CH_LC_A && ch <= CH_LC_Z) ? ch - CH_CASE : ch;
  assign is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
  assign is_digit = !end_of_text && (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign is_dot   = !end_of_text && (ch == CH_DOT);
  assign is_pct   = (ch == CH_PCT);
  assign digit    = 4'(ch - CH_ZERO);
  assign pair_ok  = !end_of_text && unit_pair_ok(eff_uf, up);

  always_comb begin
    is_unit1 = 1'b1;
    uf_code  = UF_E;
    case (up)
      CH_E:    uf_code = UF_E;
      CH_P:    uf_code = UF_P;
      CH_M:    uf_code = UF_M;
      CH_C:    uf_code = UF_C;
      CH_I:    uf_code = UF_I;
      default: is_unit1 = 1'b0;
    endcase
  end

  // Integer digit step, saturating at the magnitude cap.
  logic [MAG_W+3:0] int_x10;
  logic [MAG_W-1:0] int_acc;
  assign int_x10 = {1'b0, eff_int, 3'b000} + {3'b000, eff_int, 1'b0} + (MAG_W + 4)'(digit);
  assign int_acc = (int_x10 > (MAG_W + 4)'(MAG_CAP)) ? MAG_CAP : int_x10[MAG_W-1:0];

  // Next state.
  always_comb begin
    phase_nxt = eff_phase;
    int_nxt   = eff_int;
    neg_nxt   = eff_neg;
    frac_nxt  = eff_frac;
    fd_nxt    = eff_fd;
    uf_nxt    = eff_uf;
    cnt_add   = 2'd0;
    case (eff_phase)
      PH_WS: begin
        if (end_of_text) begin
          phase_nxt = PH_IDLE;
        end else if (is_space) begin
          cnt_add = 2'd1;
        end else if (is_sign) begin
          neg_nxt   = (ch == CH_MINUS);
          phase_nxt = PH_SIGN;
        end else if (is_digit) begin
          int_nxt   = MAG_W'(digit);
          cnt_add   = 2'd1;
          phase_nxt = PH_INT;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_SIGN: begin
        if (is_digit) begin
          int_nxt   = MAG_W'(digit);
          cnt_add   = 2'd2;
          phase_nxt = PH_INT;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_INT, PH_DOT, PH_FRAC1, PH_FRAC2: begin
        if (is_digit) begin
          cnt_add = 2'd1;
          case (eff_phase)
            PH_INT: int_nxt = int_acc;
            PH_DOT: begin
              frac_nxt  = FRAC_W'(digit);
              fd_nxt    = 2'd1;
              phase_nxt = PH_FRAC1;
            end
            PH_FRAC1: begin
              frac_nxt  = {eff_frac[FRAC_W-4:0], 3'b000} + {eff_frac[FRAC_W-2:0], 1'b0}
                          + FRAC_W'(digit);
              fd_nxt    = 2'd2;
              phase_nxt = PH_FRAC2;
            end
            default: phase_nxt = eff_phase;
          endcase
        end else if (eff_phase == PH_INT && is_dot) begin
          cnt_add   = 2'd1;
          phase_nxt = PH_DOT;
        end else if (end_of_text) begin
          phase_nxt = PH_IDLE;
        end else if (is_unit1) begin
          uf_nxt    = uf_code;
          phase_nxt = PH_UNIT2;
        end else if (is_pct) begin
          cnt_add   = 2'd1;
          phase_nxt = PH_IDLE;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_UNIT2: begin
        if (pair_ok) begin
          cnt_add = 2'd2;
        end
        phase_nxt = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Character count, saturating at the scan length limit.
  logic [CW:0]     cnt_sum;
  logic [CXW-1:0]  cnt_ext;
  assign cnt_sum = {1'b0, eff_cnt} + (CW + 1)'(cnt_add);
  assign cnt_nxt = (cnt_sum > CNT_MAX) ? CNT_MAX[CW-1:0] : cnt_sum[CW-1:0];
  assign cnt_ext = CXW'(cnt_nxt);

  // Result generation.
  logic        emit_num, emit_nonum;
  logic [15:0] unit_sel;

  always_comb begin
    emit_num   = 1'b0;
    emit_nonum = 1'b0;
    unit_sel   = UNIT_NONE;
    case (eff_phase)
      PH_WS: begin
        emit_nonum = end_of_text || !(is_space || is_sign || is_digit);
      end
      PH_SIGN: begin
        emit_nonum = !is_digit;
      end
      PH_INT, PH_DOT, PH_FRAC1, PH_FRAC2: begin
        if (is_digit || (eff_phase == PH_INT && is_dot)) begin
          emit_num = 1'b0;
        end else if (end_of_text) begin
          emit_num = 1'b1;
        end else if (is_unit1) begin
          emit_num = 1'b0;
        end else begin
          emit_num = 1'b1;
          unit_sel = is_pct ? UNIT_PCT : UNIT_NONE;
        end
      end
      PH_UNIT2: begin
        emit_num = 1'b1;
        unit_sel = pair_ok ? {uf_char(eff_uf), up} : UNIT_NONE;
      end
      default: emit_num = 1'b0;
    endcase
  end

  assign emit_valid       = emit_num || emit_nonum;
  assign emit.nonum       = emit_nonum;
  assign emit.neg         = eff_neg;
  assign emit.mag         = eff_int;
  assign emit.frac        = eff_frac;
  assign emit.frac_digits = eff_fd;
  assign emit.unit        = unit_sel;
  assign emit.consumed    = (cnt_ext > CONS_MAX) ? 8'd255 : cnt_ext[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      int_r   <= '0;
      neg_r   <= 1'b0;
      frac_r  <= '0;
      fd_r    <= 2'd0;
      uf_r    <= UF_E;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      int_r   <= int_nxt;
      neg_r   <= neg_nxt;
      frac_r  <= frac_nxt;
      fd_r    <= fd_nxt;
      uf_r    <= uf_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/dlup_fmt.sv -----
// Result formatter: signed 16.8 scaling with rounding, range check, sign and clamping.
// Depends on dlup_pkg.
module dlup_fmt (
  input  dlup_pkg::dlup_emit_t    emit,
  output dlup_pkg::dlup_status_t  status,
  output logic signed [24:0]      value
);
  import dlup_pkg::*;

  logic                    wide;
  logic [7:0]              frac_q;
  logic [VALUE_W-1:0]      scaled;
  logic [VALUE_W-1:0]      mag_sel;
  logic signed [VALUE_W:0] signed_val;
  logic signed [VALUE_W:0] clamped;

  assign wide = emit.neg ? (emit.mag > INT_NEG_MAX) : (emit.mag > INT_POS_MAX);

  // The integer part scales exactly, so only the fraction needs rounding.
  always_comb begin
    case (emit.frac_digits)
      2'd1:    frac_q = FRAC1_LUT[emit.frac[3:0]];
      2'd2:    frac_q = FRAC2_LUT[emit.frac];
      default: frac_q = 8'd0;
    endcase
  end

  assign scaled     = {emit.mag[16:0], 8'h00} + VALUE_W'(frac_q);
  assign mag_sel    = wide ? VALUE_W'(emit.mag) : scaled;
  assign signed_val = emit.neg ? -$signed({1'b0, mag_sel}) : $signed({1'b0, mag_sel});

  always_comb begin
    if (signed_val < VAL_LOW) begin
      clamped = VAL_LOW;
    end else if (signed_val > VAL_HIGH) begin
      clamped = VAL_HIGH;
    end else begin
      clamped = signed_val;
    end
  end

  always_comb begin
    if (emit.nonum) begin
      status = ST_NONUM;
      value  = '0;
    end else begin
      status = wide ? ST_RANGE : ST_OK;
      value  = clamped[VALUE_W-1:0];
    end
  end

endmodule

// ----- rtl/decimal_length_unit_parser_top.sv -----
// Length token parser: one text character per cycle in, unless the result register is
// stalled, and one result per token out. A token's result is registered as its last
// character leaves the input register. The only state loop is the scanner update.
// Reset (rst_n low, synchronous): scanner idle, counters and accumulators zero, both
// channel registers empty. No clearing pass is needed.
// Depends on dlup_pkg, dlup_if, dlup_scan and dlup_fmt.
module decimal_length_unit_parser_top #(
  parameter int MAX_SCAN_LENGTH = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  dlup_in_if.sink    in_ch,
  dlup_out_if.source out_res
);
  import dlup_pkg::*;

  // Input register. A character waits here until the result register can take
  // whatever the scanner produces for it.
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] ch_r;
  logic       first_r;
  logic       eot_r;
  logic       step_go;

  assign step_go      = in_valid_r && (!out_res.valid || out_res.ready);
  assign in_ch.ready  = !in_valid_r || step_go;
  assign in_valid_nxt = in_ch.valid ? 1'b1 : (step_go ? 1'b0 : in_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      ch_r    <= in_ch.ch;
      first_r <= in_ch.first;
      eot_r   <= in_ch.end_of_text;
    end
  end

  // The scanner advances by exactly one character per step and reports when the
  // character finishes a token.
  logic       emit_valid;
  dlup_emit_t emit;

  dlup_scan #(
    .MAX_SCAN_LENGTH(MAX_SCAN_LENGTH)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step_go),
    .ch         (ch_r),
    .first      (first_r),
    .end_of_text(eot_r),
    .emit_valid (emit_valid),
    .emit       (emit)
  );

  dlup_status_t       fmt_status;
  logic signed [24:0] fmt_value;

  dlup_fmt u_fmt (
    .emit  (emit),
    .status(fmt_status),
    .value (fmt_value)
  );

  // Result register. It is loaded only when it is empty or its transaction
  // completes in the same cycle, so no result is dropped or repeated.
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         status_r;
  logic signed [24:0] value_r;
  logic [15:0]        unit_r;
  logic [7:0]         consumed_r;
  logic               load_out;

  assign load_out      = step_go && emit_valid;
  assign out_valid_nxt = load_out ? 1'b1 : (out_res.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status_r   <= fmt_status;
      value_r    <= fmt_value;
      unit_r     <= emit.unit;
      consumed_r <= emit.consumed;
    end
  end

  assign out_res.valid    = out_valid_r;
  assign out_res.status   = status_r;
  assign out_res.value    = value_r;
  assign out_res.unit     = unit_r;
  assign out_res.consumed = consumed_r;

  // A finished token always shows up in the result register on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) load_out |=> out_valid_r)
    else $error("finished token did not reach the result register");

  // The scanner never advances while a waiting result would be overwritten.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid_r && !out_res.ready) |-> !step_go)
    else $error("scanner stepped while the result register was stalled");

  // A token without digits carries neither a value nor a unit.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid_r && status_r == ST_NONUM) |-> (value_r == '0 && unit_r == UNIT_NONE))
    else $error("no-number result carries a value or unit");

  // Only the three defined status codes are ever produced.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid_r |-> (status_r == ST_OK || status_r == ST_NONUM ||
                                    status_r == ST_RANGE))
    else $error("undefined status code in result");

endmodule

// ----- bench/length_token_checker.sv -----
// Checker for the length token parser: follows both channels, predicts every result
// from the accepted characters and compares it field by field with what the block returns.
// Depends on dlup_pkg and the channel interfaces of dlup_if.
module length_token_checker
  import dlup_pkg::*;
#(
  parameter int SCAN_LIMIT = 255
) (
  input  logic clk,
  input  logic rst_n,
  dlup_in_if   in_ch,
  dlup_out_if  out_res,
  output int   fail_count,
  output int   pending,
  output int   chars_taken,
  output int   tokens_ok,
  output int   tokens_nonum,
  output int   tokens_range
);

  localparam longint VAL_FLOOR = -64'sd8388736;
  localparam longint VAL_CEIL  = 64'sd8388607;

  typedef struct packed {
    dlup_status_t               status;
    logic signed [VALUE_W-1:0]  value;
    logic [15:0]                unit;
    logic [7:0]                 consumed;
  } token_result_t;

  token_result_t expected_tokens[$];
  int            tokens_checked;

  // Scanner state of the prediction.
  dlup_phase_t       scan_phase;
  logic [MAG_W-1:0]  mag_acc;
  logic              is_neg;
  logic [FRAC_W-1:0] frac_acc;
  logic [1:0]        frac_cnt;
  logic [7:0]        held_letter;
  int                char_cnt;

  function automatic bit is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= CH_LC_A && c <= CH_LC_Z) ? 8'(c - CH_CASE) : c;
  endfunction

  function automatic bit pair_known(logic [7:0] a, logic [7:0] b);
    case (a)
      CH_E:    return (b == CH_M) || (b == CH_X);
      CH_P:    return (b == CH_C) || (b == CH_T) || (b == CH_X);
      CH_M:    return b == CH_M;
      CH_C:    return b == CH_M;
      CH_I:    return b == CH_N;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void bump(int n);
    char_cnt = (char_cnt + n > SCAN_LIMIT) ? SCAN_LIMIT : char_cnt + n;
  endfunction

  function automatic void clear_scan();
    scan_phase  = PH_IDLE;
    mag_acc     = '0;
    is_neg      = 1'b0;
    frac_acc    = '0;
    frac_cnt    = '0;
    held_letter = '0;
    char_cnt    = 0;
  endfunction

  // Every token ends here: the value is clamped and the scanner goes idle.
  function automatic token_result_t close_token(dlup_status_t st, longint v, logic [15:0] u);
    token_result_t r;
    if (v < VAL_FLOOR) v = VAL_FLOOR;
    else if (v > VAL_CEIL) v = VAL_CEIL;
    r.status   = st;
    r.value    = v[VALUE_W-1:0];
    r.unit     = u;
    r.consumed = (char_cnt > 255) ? 8'd255 : char_cnt[7:0];
    scan_phase = PH_IDLE;
    return r;
  endfunction

  // Integers outside the 16-bit range come back raw; the rest as rounded 16.8 values.
  function automatic token_result_t close_number(logic [15:0] u);
    longint m, s;
    m = longint'(mag_acc);
    if (is_neg ? (m > longint'(INT_NEG_MAX)) : (m > longint'(INT_POS_MAX)))
      return close_token(ST_RANGE, is_neg ? -m : m, u);
    case (frac_cnt)
      2'd0:    s = m * 256;
      2'd1:    s = ((m * 10 + longint'(frac_acc)) * 256 + 5) / 10;
      default: s = ((m * 100 + longint'(frac_acc)) * 256 + 5) / 100;
    endcase
    return close_token(ST_OK, is_neg ? -s : s, u);
  endfunction

  task automatic open_unit(input logic [7:0] cu, input logic e,
                           output bit made, output token_result_t r);
    made = 1'b1;
    r    = '0;
    if (e) begin
      r = close_number(UNIT_NONE);
    end else if (cu == CH_E || cu == CH_P || cu == CH_M || cu == CH_C || cu == CH_I) begin
      held_letter = cu;
      scan_phase  = PH_UNIT2;
      made        = 1'b0;
    end else if (cu == CH_PCT) begin
      bump(1);
      r = close_number(UNIT_PCT);
    end else begin
      r = close_number(UNIT_NONE);
    end
  endtask

  task automatic scan_char(input logic [7:0] c, input logic f, input logic e,
                           output bit made, output token_result_t r);
    logic [7:0] cu;
    logic [7:0] d;
    bit         dig;
    longint     grown;
    cu   = upcase(c);
    d    = c - CH_ZERO;
    dig  = !e && is_num(c);
    made = 1'b0;
    r    = '0;
    if (f) begin
      clear_scan();
      scan_phase = PH_WS;
    end
    case (scan_phase)
      PH_WS: begin
        if (e) begin
          made = 1'b1;
          r    = close_token(ST_NONUM, 0, UNIT_NONE);
        end else if (is_blank(c)) begin
          bump(1);
        end else if (c == CH_MINUS || c == CH_PLUS) begin
          is_neg     = (c == CH_MINUS);
          scan_phase = PH_SIGN;
        end else if (dig) begin
          mag_acc    = MAG_W'(d);
          scan_phase = PH_INT;
          bump(1);
        end else begin
          made = 1'b1;
          r    = close_token(ST_NONUM, 0, UNIT_NONE);
        end
      end
      PH_SIGN: begin
        // The sign only counts once a digit follows it.
        if (dig) begin
          mag_acc    = MAG_W'(d);
          scan_phase = PH_INT;
          bump(2);
        end else begin
          made = 1'b1;
          r    = close_token(ST_NONUM, 0, UNIT_NONE);
        end
      end
      PH_INT: begin
        if (dig) begin
          grown   = longint'(mag_acc) * 10 + longint'(d);
          mag_acc = (grown > longint'(MAG_CAP)) ? MAG_CAP : grown[MAG_W-1:0];
          bump(1);
        end else if (!e && c == CH_DOT) begin
          scan_phase = PH_DOT;
          bump(1);
        end else begin
          open_unit(cu, e, made, r);
        end
      end
      PH_DOT: begin
        if (dig) begin
          frac_acc   = FRAC_W'(d);
          frac_cnt   = 2'd1;
          scan_phase = PH_FRAC1;
          bump(1);
        end else begin
          open_unit(cu, e, made, r);
        end
      end
      PH_FRAC1: begin
        if (dig) begin
          frac_acc   = FRAC_W'(frac_acc * 10 + d);
          frac_cnt   = 2'd2;
          scan_phase = PH_FRAC2;
          bump(1);
        end else begin
          open_unit(cu, e, made, r);
        end
      end
      PH_FRAC2: begin
        // Digits past the second are counted but do not change the value.
        if (dig) bump(1);
        else open_unit(cu, e, made, r);
      end
      PH_UNIT2: begin
        made = 1'b1;
        if (!e && pair_known(held_letter, cu)) begin
          bump(2);
          r = close_number({held_letter, cu});
        end else begin
          r = close_number(UNIT_NONE);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 100) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    bit            made;
    token_result_t want;
    if (!rst_n) begin
      clear_scan();
      expected_tokens.delete();
      tokens_checked = 0;
      fail_count     = 0;
      chars_taken    = 0;
      tokens_ok      = 0;
      tokens_nonum   = 0;
      tokens_range   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        chars_taken++;
        scan_char(in_ch.ch, in_ch.first, in_ch.end_of_text, made, want);
        if (made) expected_tokens.push_back(want);
      end
      if (out_res.valid && out_res.ready) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("result with none expected: status %0d value %0d unit %h n %0d",
                                    out_res.status, out_res.value, out_res.unit,
                                    out_res.consumed));
        end else begin
          want = expected_tokens.pop_front();
          tokens_checked++;
          case (want.status)
            ST_OK:    tokens_ok++;
            ST_NONUM: tokens_nonum++;
            default:  tokens_range++;
          endcase
          if (out_res.status !== want.status)
            report_mismatch($sformatf("token %0d: status %0d, expected %0d",
                                      tokens_checked, out_res.status, want.status));
          if (out_res.value !== want.value)
            report_mismatch($sformatf("token %0d: value %0d, expected %0d",
                                      tokens_checked, out_res.value, want.value));
          if (out_res.unit !== want.unit)
            report_mismatch($sformatf("token %0d: unit %h, expected %h",
                                      tokens_checked, out_res.unit, want.unit));
          if (out_res.consumed !== want.consumed)
            report_mismatch($sformatf("token %0d: consumed %0d, expected %0d",
                                      tokens_checked, out_res.consumed, want.consumed));
        end
      end
    end
    pending <= expected_tokens.size();
  end

endmodule

// ----- bench/tb_decimal_length_unit_parser_top.sv -----
// Top of the length token parser testbench: clock, reset, character stimulus and
// result back-pressure, with the verdict taken from the checker beside the block.
// Depends on dlup_pkg, dlup_if, the parser RTL and length_token_checker.
module tb_decimal_length_unit_parser_top;
  import dlup_pkg::*;

  localparam int SCAN_LIMIT   = 255;
  localparam int RANDOM_ITEMS = 1850;
  localparam int LIMIT_CYCLES = 500000;

  // The eight two-letter units, high letter first.
  localparam logic [15:0] UNIT_PAIRS [8] = '{
    {CH_E, CH_M}, {CH_E, CH_X}, {CH_P, CH_C}, {CH_P, CH_T},
    {CH_P, CH_X}, {CH_M, CH_M}, {CH_C, CH_M}, {CH_I, CH_N}
  };

  // One character transaction as the sender sees it.
  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic       eot;
  } text_item_t;

  logic clk = 1'b0;
  logic rst_n;

  int fail_count;
  int pending;
  int chars_taken;
  int tokens_ok;
  int tokens_nonum;
  int tokens_range;

  text_item_t line_q[$];
  int         send_calm;
  int         recv_calm;
  int         tokens_sent;

  dlup_in_if  in_ch();
  dlup_out_if out_res();

  decimal_length_unit_parser_top #(
    .MAX_SCAN_LENGTH(SCAN_LIMIT)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_res(out_res)
  );

  length_token_checker #(
    .SCAN_LIMIT(SCAN_LIMIT)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_res     (out_res),
    .fail_count  (fail_count),
    .pending     (pending),
    .chars_taken (chars_taken),
    .tokens_ok   (tokens_ok),
    .tokens_nonum(tokens_nonum),
    .tokens_range(tokens_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Both sides draw a random wait per transaction. Now and then a calm stretch
  // of back-to-back transactions is chosen so that full-rate operation is
  // exercised as well.
  task automatic pick_wait(inout int calm, output int n);
    int r;
    if (calm > 0) begin
      calm--;
      n = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        calm = $urandom_range(8, 40);
        n    = 0;
      end else if (r < 45) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 16);
      end
    end
  endtask

  // Drives one character and returns at the edge where the block takes it. Valid
  // stays high across back-to-back transactions and is dropped only for a gap.
  task automatic send_item(input text_item_t it);
    int gap;
    pick_wait(send_calm, gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.ch          <= it.ch;
    in_ch.first       <= it.first;
    in_ch.end_of_text <= it.eot;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic flush_line();
    while (line_q.size() != 0) send_item(line_q.pop_front());
    tokens_sent++;
  endtask

  // Holds the sender off until the block has returned every result owed so far.
  // The first edge lets the checker account for the last accepted character.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic add_ch(input logic [7:0] c);
    line_q.push_back('{ch: c, first: 1'b0, eot: 1'b0});
  endtask

  // The character byte is meaningless at the end of the text, so it is random.
  task automatic add_eot();
    line_q.push_back('{ch: 8'($urandom), first: 1'b0, eot: 1'b1});
  endtask

  // A directed token: its first character starts a new scan.
  task automatic add_token(input string s, input bit with_eot);
    for (int i = 0; i < s.len(); i++) line_q.push_back('{ch: s[i], first: (i == 0), eot: 1'b0});
    if (with_eot) add_eot();
  endtask

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 5) == 5) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] any_case(logic [7:0] c);
    return $urandom_range(0, 1) ? 8'(c + CH_CASE) : c;
  endfunction

  // Builds one random token into line_q. Most tokens are well formed with random
  // content; the rest are raw noise bytes. long_kind forces a very long run of
  // leading white space (1) or of fraction digits (2) to drive the counts into
  // saturation.
  task automatic add_random_token(input int long_kind);
    int          n;
    int          pick;
    logic [15:0] pair;
    if (long_kind == 0 && $urandom_range(0, 99) < 12) begin
      n = $urandom_range(1, 6);
      repeat (n) line_q.push_back('{ch: 8'($urandom), first: 1'b0,
                                    eot: ($urandom_range(0, 9) == 0)});
      line_q[0].first = 1'b1;
      return;
    end
    n = (long_kind == 1) ? 262 : (($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0);
    repeat (n) add_ch(blank_char());
    pick = $urandom_range(0, 3);
    if (pick == 0) add_ch(CH_PLUS);
    else if (pick == 1) add_ch(CH_MINUS);
    pick = $urandom_range(0, 99);
    n = (pick < 6) ? 0 : (pick < 70) ? $urandom_range(1, 3) :
        (pick < 90) ? $urandom_range(4, 5) : $urandom_range(6, 9);
    repeat (n) add_ch(digit_char());
    if (long_kind == 2 || $urandom_range(0, 1) == 1) begin
      add_ch(CH_DOT);
      n = (long_kind == 2) ? 270 : $urandom_range(0, 4);
      repeat (n) add_ch(digit_char());
    end
    // Unit: a proper pair, percent, a first letter with a random partner, a lone
    // first letter, or none.
    pick = $urandom_range(0, 99);
    pair = UNIT_PAIRS[$urandom_range(0, 7)];
    if (pick < 45) begin
      add_ch(any_case(pair[15:8]));
      add_ch(any_case(pair[7:0]));
    end else if (pick < 53) begin
      add_ch(CH_PCT);
    end else if (pick < 63) begin
      add_ch(any_case(pair[15:8]));
      add_ch(8'($urandom));
    end else if (pick < 70) begin
      add_ch(any_case(pair[15:8]));
    end
    // Terminator: end of text, a random byte, white space, or none at all so
    // that the next token restarts a running scan.
    pick = $urandom_range(0, 99);
    if (pick < 45) add_eot();
    else if (pick < 75) add_ch(8'($urandom));
    else if (pick < 88) add_ch(blank_char());
    if (line_q.size() == 0) add_ch(8'($urandom));
    line_q[0].first = 1'b1;
  endtask

  // Result side: random stalls of the ready line, one draw per transaction.
  initial begin : result_sink
    int stall;
    out_res.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      pick_wait(recv_calm, stall);
      if (stall > 0) begin
        out_res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_res.ready <= 1'b1;
      @(posedge clk);
      while (out_res.valid !== 1'b1) @(posedge clk);
    end
  end

  // Character side: reset, directed tokens, then random tokens.
  initial begin : text_source
    int budget;
    int token_idx;
    int extra;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.ch          = '0;
    in_ch.first       = 1'b0;
    in_ch.end_of_text = 1'b0;
    send_calm         = 0;
    recv_calm         = 0;
    tokens_sent       = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed tokens. Range edges on both sides, the largest fraction, integer
    // saturation, every white space byte, a dot with no digit after it, unknown
    // and unfinished units, a lone sign, blank and empty text, and a restart.
    add_token("0", 1'b1);
    add_token("\t+0.005pt", 1'b0);
    add_token("-32768%", 1'b0);
    add_token("32767.99PX", 1'b0);
    add_token("-32768.99em", 1'b0);
    add_token("32768Mm", 1'b0);
    add_token("99999999999", 1'b1);
    add_token("-99999999999in", 1'b0);
    add_token("\n 1.", 1'b1);
    add_token("7.x", 1'b0);
    add_token("5e", 1'b1);
    add_token("5eq", 1'b0);
    add_token("0.125cM", 1'b0);
    add_token("- ", 1'b0);
    add_token(" ", 1'b1);
    add_token("q", 1'b0);
    add_token("12", 1'b0);
    add_token("34In", 1'b0);
    flush_line();
    // Characters with no scan running are ignored.
    add_ch(CH_NINE);
    add_eot();
    // Byte extremes as whole tokens, and end of text as the very first character.
    line_q.push_back('{ch: 8'h00, first: 1'b1, eot: 1'b0});
    line_q.push_back('{ch: 8'hFF, first: 1'b1, eot: 1'b0});
    line_q.push_back('{ch: 8'hFF, first: 1'b1, eot: 1'b1});
    add_token("+12.3Ex", 1'b0);
    add_token("\v\f\0154.5mm", 1'b0);
    flush_line();

    // At least once, the sender waits for every owed result before going on.
    drain();

    budget    = 0;
    token_idx = 0;
    while (budget < RANDOM_ITEMS) begin
      add_random_token((token_idx == 30) ? 1 : (token_idx == 75) ? 2 : 0);
      budget += line_q.size();
      // A few trailing bytes with no start flag; ignored when the token has ended.
      if ($urandom_range(0, 4) == 0) begin
        extra = $urandom_range(1, 2);
        repeat (extra) line_q.push_back('{ch: 8'($urandom), first: 1'b0,
                                          eot: $urandom_range(0, 1)});
      end
      flush_line();
      token_idx++;
      if (token_idx % 70 == 0) drain();
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Sent %0d batches of tokens as %0d characters with random gaps and stalls.",
             tokens_sent, chars_taken);
    $display("Results compared: %0d ok, %0d without a number, %0d out of 16-bit range.",
             tokens_ok, tokens_nonum, tokens_range);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard limit on the run, far above the slowest correct run.
  initial begin : watchdog
    #(LIMIT_CYCLES * 10);
    $display("Timeout after %0d cycles with %0d results still owed.", LIMIT_CYCLES, pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
